FILE: src/arw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window package
// Command and verdict codes and the sequencer state type.
// ----------------------------------------------------------------------------
package arw_pkg;

	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	localparam logic [1:0] CMD_MARK  = 2'd0;
	localparam logic [1:0] CMD_CHECK = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	localparam logic [1:0] VERDICT_OK  = 2'd0;
	localparam logic [1:0] VERDICT_OLD = 2'd1;
	localparam logic [1:0] VERDICT_DUP = 2'd2;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_SUB1   = 10'b00_0000_0100,
		S_SUB2   = 10'b00_0000_1000,
		S_JUDGE  = 10'b00_0001_0000,
		S_RREAD  = 10'b00_0010_0000,
		S_RWRITE = 10'b00_0100_0000,
		S_MREAD  = 10'b00_1000_0000,
		S_MWRITE = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

endpackage

FILE: src/arw_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay ring bitmap
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arw_ring #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: src/anti_replay_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay sliding window
// Checks 64-bit packet counters against the highest accepted counter and a
// ring bitmap of recently seen counters; mark commands record accepted ones.
//
//   channel | signals                        | direction
//   req     | req_valid, req_ready, command, counter | into block
//   rsp     | rsp_valid, rsp_ready, verdict  | out of block
//
// A check-only or rejected transaction steps through S_SUB1, S_SUB2, S_JUDGE
// and S_DONE; a mark inside the window adds S_MWRITE. A forward move adds an
// S_RREAD and S_RWRITE pair per ring word whose bits are cleared, then S_MREAD
// and S_MWRITE. A full clear, a first packet and a reset command walk the
// ring one word per cycle, as does reset, with req_ready low. A stalled
// response is held in its own register while the next request is taken.
// ----------------------------------------------------------------------------
module anti_replay_window
	import arw_pkg::*;
#(
	parameter int WINDOW     = 2048,
	parameter int RING_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  command,
	input  logic [63:0] counter,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  verdict
);

	localparam int AW = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(RING_WORDS - 1);
	localparam logic [57:0]   RING_MASK = 58'(RING_WORDS - 1);
	localparam logic [63:0]   WIN       = 64'(WINDOW);
	localparam logic [63:0]   RING_BITS = 64'(RING_WORDS) * 64'(WORD_BITS);

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic          clr_mark_q;
	logic          clr_rsp_q;
	logic          started_q;
	logic [63:0]   high_q;
	logic [1:0]    cmd_q;
	logic [63:0]   cnt_q;
	logic [64:0]   diff_q;
	logic [63:0]   back_q;
	logic [63:0]   lo_q;
	logic [63:0]   last_q;
	logic [57:0]   w_q;
	logic [1:0]    vrd_q;
	logic          rsp_valid_q;
	logic [1:0]    verdict_q;

	logic [63:0]   sub_a;
	logic [63:0]   sub_b;
	logic [64:0]   sub_res;
	logic [AW-1:0] word_c;
	logic [AW-1:0] word_w;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [63:0]   rd_data;
	logic          ahead;
	logic          too_old;
	logic [1:0]    verdict_c;
	logic          full_clear;
	logic [5:0]    lo_b;
	logic [5:0]    hi_b;
	logic [63:0]   clr_mask;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign verdict   = verdict_q;

	assign word_c = AW'(cnt_q[63:6] & RING_MASK);
	assign word_w = AW'(w_q & RING_MASK);

	// Shared subtractor: counter minus highest, then highest minus counter.
	always_comb begin
		sub_a   = (state_q == S_SUB2) ? high_q : cnt_q;
		sub_b   = (state_q == S_SUB2) ? cnt_q : high_q;
		sub_res = {1'b0, sub_a} - {1'b0, sub_b};
	end

	always_comb begin
		ahead      = !diff_q[64] && (diff_q[63:0] != 64'd0);
		too_old    = diff_q[64] && (back_q >= WIN);
		full_clear = (diff_q[63:0] >= WIN) || (diff_q[63:0] > RING_BITS);
		if (!started_q || ahead) begin
			verdict_c = VERDICT_OK;
		end else if (too_old) begin
			verdict_c = VERDICT_OLD;
		end else if (rd_data[cnt_q[5:0]]) begin
			verdict_c = VERDICT_DUP;
		end else begin
			verdict_c = VERDICT_OK;
		end
	end

	always_comb begin
		lo_b     = (w_q == lo_q[63:6]) ? lo_q[5:0] : 6'd0;
		hi_b     = (w_q == last_q[63:6]) ? last_q[5:0] : 6'd63;
		clr_mask = ({64{1'b1}} << lo_b) & ({64{1'b1}} >> (6'd63 - hi_b));
	end

	always_comb begin
		mem_raddr = (state_q == S_RREAD) ? word_w : word_c;
		mem_we    = 1'b0;
		mem_waddr = word_c;
		mem_wdata = rd_data | (64'd1 << cnt_q[5:0]);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 64'd0;
			end
			S_RWRITE: begin
				mem_we    = 1'b1;
				mem_waddr = word_w;
				mem_wdata = rd_data & ~clr_mask;
			end
			S_MWRITE: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	arw_ring #(
		.DEPTH(RING_WORDS),
		.AW   (AW)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				cnt_q <= counter;
			end
			S_SUB1: begin
				diff_q <= sub_res;
			end
			S_SUB2: begin
				back_q <= sub_res[63:0];
			end
			S_JUDGE: begin
				lo_q   <= high_q + 64'd1;
				last_q <= cnt_q - 64'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			clr_mark_q <= 1'b0;
			clr_rsp_q  <= 1'b0;
			started_q  <= 1'b0;
			high_q     <= 64'd0;
			w_q        <= 58'd0;
			vrd_q      <= VERDICT_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						clr_q <= '0;
						if (clr_mark_q) begin
							state_q <= S_MREAD;
						end else if (clr_rsp_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						if (command == CMD_RESET) begin
							started_q  <= 1'b0;
							high_q     <= 64'd0;
							vrd_q      <= VERDICT_OK;
							clr_mark_q <= 1'b0;
							clr_rsp_q  <= 1'b1;
							clr_q      <= '0;
							state_q    <= S_CLEAR;
						end else begin
							state_q <= S_SUB1;
						end
					end
				end
				S_SUB1: begin
					state_q <= S_SUB2;
				end
				S_SUB2: begin
					state_q <= S_JUDGE;
				end
				S_JUDGE: begin
					vrd_q <= verdict_c;
					if (cmd_q == CMD_MARK && verdict_c == VERDICT_OK) begin
						if (!started_q || ahead) begin
							started_q <= 1'b1;
							high_q    <= cnt_q;
						end
						if (!started_q || (ahead && full_clear)) begin
							clr_mark_q <= 1'b1;
							clr_rsp_q  <= 1'b1;
							clr_q      <= '0;
							state_q    <= S_CLEAR;
						end else if (ahead && diff_q[63:0] == 64'd1) begin
							state_q <= S_MREAD;
						end else if (ahead) begin
							w_q     <= high_q[63:6] + 58'(high_q[5:0] == 6'd63);
							state_q <= S_RREAD;
						end else begin
							state_q <= S_MWRITE;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RREAD: begin
					state_q <= S_RWRITE;
				end
				S_RWRITE: begin
					if (w_q == last_q[63:6]) begin
						state_q <= S_MREAD;
					end else begin
						w_q     <= w_q + 58'd1;
						state_q <= S_RREAD;
					end
				end
				S_MREAD: begin
					state_q <= S_MWRITE;
				end
				S_MWRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			verdict_q <= vrd_q;
		end
	end

endmodule

FILE: src/arw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window checker
// Port-level properties of the anti-replay window, bound to the top level.
// ----------------------------------------------------------------------------
module arw_checker
	import arw_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] verdict
);

	// A response waits for the consumer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled verdict keeps its value.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(verdict))
		else $error("verdict changed while stalled");

	// Only defined verdict codes are shown.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_OLD ||
			verdict == VERDICT_DUP))
		else $error("undefined verdict code");

	// The block works on one transaction at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// No response appears in the cycle right after a request is taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

endmodule

bind anti_replay_window arw_checker u_arw_checker (.*);

FILE: test/tb_anti_replay_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Anti-replay window testbench
// Drives command and counter transactions into the window, first from a
// directed table of boundary cases and then from random packet streams that
// stay mostly near the top of the window. Each verdict is compared with a
// table value or a ring bitmap model, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_anti_replay_window;
	import arw_pkg::*;

	localparam int WINDOW     = 2048;
	localparam int RING_WORDS = 32;
	localparam int RING_BITS  = RING_WORDS * WORD_BITS;
	localparam int N_RANDOM   = 1700;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] cnt;
		logic        fixed;
		logic [1:0]  verdict;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  command = CMD_MARK;
	logic [63:0] counter = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [1:0]  verdict;

	logic [RING_BITS-1:0] ring_map = '0;
	logic [63:0]          top_seen = '0;
	logic                 window_open = 1'b0;

	logic [1:0] verdict_q[$];
	int         mismatches = 0;
	int         burst_left = 0;
	bit         random_phase = 1'b0;

	stim_row_t directed_rows [25] = '{
		'{CMD_CHECK, 64'd0,    1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd100,  1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd100,  1'b1, VERDICT_DUP},
		'{CMD_CHECK, 64'd100,  1'b1, VERDICT_DUP},
		'{CMD_MARK,  64'd99,   1'b0, VERDICT_OK},
		'{CMD_MARK,  64'd99,   1'b1, VERDICT_DUP},
		'{CMD_MARK,  64'd2147, 1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd99,   1'b1, VERDICT_OLD},
		'{CMD_MARK,  64'd100,  1'b0, VERDICT_OK},
		'{CMD_MARK,  64'd2146, 1'b0, VERDICT_OK},
		'{CMD_MARK,  64'd4195, 1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd2147, 1'b1, VERDICT_OLD},
		'{CMD_MARK,  64'd2148, 1'b0, VERDICT_OK},
		'{CMD_CHECK, 64'd2148, 1'b0, VERDICT_OK},
		'{CMD_SPARE, 64'd2149, 1'b0, VERDICT_OK},
		'{CMD_MARK,  64'd4196, 1'b1, VERDICT_OK},
		'{CMD_MARK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd0,    1'b1, VERDICT_OLD},
		'{CMD_MARK,  64'hFFFF_FFFF_FFFF_FFFE, 1'b0, VERDICT_OK},
		'{CMD_MARK,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, VERDICT_DUP},
		'{CMD_RESET, 64'h5555_5555_5555_5555, 1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd0,    1'b1, VERDICT_OK},
		'{CMD_MARK,  64'd0,    1'b1, VERDICT_DUP},
		'{CMD_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, VERDICT_OK},
		'{CMD_RESET, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, VERDICT_OK}
	};

	anti_replay_window #(
		.WINDOW     (WINDOW),
		.RING_WORDS (RING_WORDS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.command   (command),
		.counter   (counter),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.verdict   (verdict)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [1:0] window_step(input logic [1:0] cmd, input logic [63:0] c);
		logic [1:0]  v;
		logic [63:0] gap;
		logic [63:0] k;
		if (cmd == CMD_RESET) begin
			ring_map = '0;
			top_seen = '0;
			window_open = 1'b0;
			return VERDICT_OK;
		end
		if (!window_open || c > top_seen)
			v = VERDICT_OK;
		else if (top_seen - c >= WINDOW)
			v = VERDICT_OLD;
		else if (ring_map[c % RING_BITS])
			v = VERDICT_DUP;
		else
			v = VERDICT_OK;
		if (cmd == CMD_MARK && v == VERDICT_OK) begin
			if (!window_open) begin
				ring_map = '0;
				top_seen = c;
				window_open = 1'b1;
			end else if (c > top_seen) begin
				gap = c - top_seen;
				if (gap >= WINDOW || gap - 1 >= RING_BITS) begin
					ring_map = '0;
				end else begin
					for (k = top_seen + 1; k < c; k++)
						ring_map[k % RING_BITS] = 1'b0;
				end
				top_seen = c;
			end
			ring_map[c % RING_BITS] = 1'b1;
		end
		return v;
	endfunction

	task automatic send_transaction(input logic [1:0] cmd, input logic [63:0] cnt,
		input logic fixed, input logic [1:0] fixed_verdict);
		logic [1:0] predicted;
		req_valid <= 1'b1;
		command   <= cmd;
		counter   <= cnt;
		do @(posedge clk); while (req_ready !== 1'b1);
		predicted = window_step(cmd, cnt);
		verdict_q.push_back(fixed ? fixed_verdict : predicted);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 60);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [63:0] cnt;
		logic [1:0]  cmd;
		int unsigned pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_transaction(directed_rows[i].cmd, directed_rows[i].cnt,
				directed_rows[i].fixed, directed_rows[i].verdict);
			pace_sender();
		end

		random_phase = 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			cmd = ($urandom_range(0, 9) == 0) ? CMD_CHECK : CMD_MARK;
			if (pick < 2) begin
				cmd = CMD_RESET;
				cnt = {$urandom, $urandom};
			end else if (pick < 5) begin
				cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE : CMD_CHECK;
				cnt = top_seen - $urandom_range(0, WINDOW + 16);
			end else if (pick < 8) begin
				cnt = {$urandom, $urandom};
			end else if (pick < 40) begin
				cnt = top_seen + $urandom_range(1, 80);
			end else if (pick < 50) begin
				cnt = top_seen + $urandom_range(81, WINDOW + 64);
			end else if (pick < 55) begin
				cnt = top_seen + $urandom_range(WINDOW, 1 << 20);
			end else if (pick < 80) begin
				cnt = top_seen - $urandom_range(0, WINDOW - 1);
			end else if (pick < 90) begin
				cnt = top_seen - $urandom_range(0, 16);
			end else begin
				cnt = top_seen - $urandom_range(WINDOW - 2, WINDOW + 200);
			end
			send_transaction(cmd, cnt, 1'b0, VERDICT_OK);
			if (n % 400 == 399) begin
				req_valid <= 1'b0;
				do @(posedge clk); while (verdict_q.size() != 0);
			end else begin
				pace_sender();
			end
		end

		req_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int  stretch;
		int  mode;
		int  hold;
		int  cyc;
		bit  held;
		stretch = 0;
		mode    = 0;
		hold    = 0;
		cyc     = 0;
		held    = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (random_phase && !held) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode    = $urandom_range(0, 3);
					stretch = $urandom_range(20, 150);
				end
				stretch--;
				case (mode)
					0: begin
						rsp_ready <= 1'b1;
					end
					1: begin
						rsp_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						rsp_ready <= (cyc % 4 == 0);
					end
					default: begin
						rsp_ready <= ($urandom_range(0, 9) != 0);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		logic [1:0] exp_verdict;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected transaction on response channel, verdict %0d", verdict);
				mismatches++;
			end else begin
				exp_verdict = verdict_q.pop_front();
				if (verdict !== exp_verdict) begin
					$error("verdict mismatch: expected %0d, actual %0d", exp_verdict, verdict);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
